// File: rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes for the periodic timer table
// Holds the command and status codes, the slot record and the cell flags.
// ----------------------------------------------------------------------------
`default_nettype none
package ptt_pkg;

    localparam int MaxReports = 16;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_KILL    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CHECK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ID    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_REJECTED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        logic        active;
        logic [15:0] id;
        logic [15:0] owner;
        logic [31:0] period;
        logic [31:0] deadline;
    } slot_t;

    // Flags a cell derives from its own record.
    typedef struct packed {
        logic expired;
        logic free;
    } cell_flags_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] id;
        logic [15:0] owner;
        logic        fired;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/ptt_cell.sv
// ----------------------------------------------------------------------------
// ptt_cell: one timer slot in the rotating slot chain
// Holds one slot record, takes its neighbor's record on a shift and reports
// whether its own timer is free or has expired.
// ----------------------------------------------------------------------------
`default_nettype none
module ptt_cell
    import ptt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        shift_en,
    input  wire slot_t       rec_in,
    input  wire logic [31:0] tick,
    output slot_t            rec_out,
    output cell_flags_t      flags
);

    slot_t rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else if (shift_en) begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out       = rec_reg;
    assign flags.free    = !rec_reg.active;
    assign flags.expired = rec_reg.active && (tick >= rec_reg.deadline);

endmodule
`default_nettype wire

// File: rtl/periodic_timer_table_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_top: table of periodic timers on a millisecond count
// Set, kill, advance and check requests against a row of timer slots.
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that rotates by one place per cycle
// while a request is worked on, unless a check stalls it; the controller
// looks only at the head cell, which holds slot 0, 1, 2 ... in turn, and
// writes the possibly changed record back into the tail, so after
// TIMER_SLOTS shifts every slot is back in place. Advance requests, sets
// with a zero interval or a full table, and kills of id zero are answered
// without a scan. Other set, kill and check requests shift the ring through
// all TIMER_SLOTS slots in S_SCAN and give the final result in S_FINISH.
// A check stalls the ring while its reports wait on the result port.
// Each check report is held one step so that the final one can carry tlast.
// A new request is taken only when the block is idle and the result register
// is free or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_timer_table_top
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[1:0], owner[17:2], interval[49:18], kill_id[65:50],
    // elapsed[97:66], report_limit[102:98], zero fill [103]
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], result_id[17:2], timer_owner[33:18], fired[34],
    // tick_now[66:35], zero fill [71:67]
    output logic [71:0]       m_tdata,
    output logic              m_tlast
);

    localparam int CW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int AW = $clog2(TIMER_SLOTS + 1);
    localparam int LimCap = (TIMER_SLOTS < MaxReports) ? TIMER_SLOTS : MaxReports;
    localparam logic [CW-1:0] LastStep = CW'(TIMER_SLOTS - 1);
    localparam logic [AW-1:0] Full = AW'(TIMER_SLOTS);

    // Unpacked request fields.
    cmd_t        in_cmd;
    logic [15:0] in_owner;
    logic [31:0] in_interval;
    logic [15:0] in_kill_id;
    logic [31:0] in_elapsed;
    logic [4:0]  in_limit;
    logic [4:0]  lim_sat;

    assign in_cmd      = cmd_t'(s_tdata[1:0]);
    assign in_owner    = s_tdata[17:2];
    assign in_interval = s_tdata[49:18];
    assign in_kill_id  = s_tdata[65:50];
    assign in_elapsed  = s_tdata[97:66];
    assign in_limit    = s_tdata[102:98];
    assign lim_sat     = (in_limit > 5'(LimCap)) ? 5'(LimCap) : in_limit;

    state_t         state_reg, state_next;
    cmd_t           cmd_reg;
    logic [15:0]    owner_reg, kill_id_reg;
    logic [31:0]    interval_reg;
    logic [4:0]     lim_reg, n_reg;
    logic [CW-1:0]  step_reg;
    logic [31:0]    tick_reg;
    logic [15:0]    id_cnt_reg;
    logic [AW-1:0]  count_reg;
    logic           done_reg;
    logic           pend_valid_reg;
    result_t        pend_reg;
    logic           out_valid_reg;
    result_t        out_reg;

    logic out_free, accept, immediate, head_hit, stall, shift_en;

    // Slot chain.
    slot_t       rec [TIMER_SLOTS];
    cell_flags_t flg [TIMER_SLOTS];
    slot_t       wb;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        slot_t rin;
        if (g == TIMER_SLOTS - 1) begin : g_tail
            assign rin = wb;
        end else begin : g_mid
            assign rin = rec[g+1];
        end
        ptt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .rec_in   (rin),
            .tick     (tick_reg),
            .rec_out  (rec[g]),
            .flags    (flg[g])
        );
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign immediate = (in_cmd == CMD_ADVANCE)
                    || (in_cmd == CMD_SET && (in_interval == '0 || count_reg >= Full))
                    || (in_cmd == CMD_KILL && in_kill_id == '0);

    assign head_hit = (cmd_reg == CMD_CHECK) && flg[0].expired && (n_reg < lim_reg);
    assign stall    = head_hit && pend_valid_reg && !out_free;
    assign shift_en = (state_reg == S_SCAN) && !stall;

    // Head processing: record written back into the tail of the ring.
    logic set_hit, kill_hit;
    assign set_hit  = (cmd_reg == CMD_SET) && flg[0].free && !done_reg;
    assign kill_hit = (cmd_reg == CMD_KILL) && !flg[0].free
                   && (rec[0].id == kill_id_reg) && !done_reg;

    always_comb begin
        wb = rec[0];
        if (set_hit) begin
            wb.active   = 1'b1;
            wb.id       = id_cnt_reg;
            wb.owner    = owner_reg;
            wb.period   = interval_reg;
            wb.deadline = tick_reg + interval_reg;
        end else if (kill_hit) begin
            wb = '0;
        end else if (head_hit) begin
            wb.deadline = rec[0].deadline + rec[0].period;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !immediate) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (shift_en && step_reg == LastStep) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result selection.
    logic    out_load;
    result_t out_next;

    always_comb begin
        out_load = 1'b0;
        out_next = '{status: ST_OK, id: '0, owner: '0, fired: 1'b0, last: 1'b1};
        unique case (state_reg)
            S_IDLE: begin
                if (accept && immediate) begin
                    out_load = 1'b1;
                    if (in_cmd == CMD_SET) begin
                        out_next.status = ST_REJECTED;
                    end else if (in_cmd == CMD_KILL) begin
                        out_next.status = ST_BAD_ID;
                    end
                end
            end
            S_SCAN: begin
                if (shift_en && head_hit && pend_valid_reg) begin
                    out_load      = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b0;
                end
            end
            S_FINISH: begin
                out_load = out_free;
                unique case (cmd_reg)
                    CMD_SET: out_next.id = id_cnt_reg;
                    CMD_KILL: begin
                        if (!done_reg) begin
                            out_next.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_CHECK: begin
                        if (pend_valid_reg) begin
                            out_next = pend_reg;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            id_cnt_reg     <= 16'd1;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            step_reg       <= '0;
            n_reg          <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                done_reg       <= 1'b0;
                step_reg       <= '0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
                if (in_cmd == CMD_ADVANCE) begin
                    tick_reg <= tick_reg + in_elapsed;
                end
            end
            if (shift_en) begin
                step_reg <= step_reg + 1'b1;
                if (set_hit || kill_hit) begin
                    done_reg <= 1'b1;
                end
                if (head_hit) begin
                    n_reg          <= n_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
            end
            if (state_reg == S_FINISH && out_free) begin
                if (cmd_reg == CMD_SET) begin
                    id_cnt_reg <= id_cnt_reg + 1'b1;
                    count_reg  <= count_reg + 1'b1;
                end else if (cmd_reg == CMD_KILL && done_reg && count_reg != '0) begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= in_cmd;
            owner_reg    <= in_owner;
            interval_reg <= in_interval;
            kill_id_reg  <= in_kill_id;
            lim_reg      <= lim_sat;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
        if (shift_en && head_hit) begin
            pend_reg <= '{status: ST_OK, id: rec[0].id, owner: rec[0].owner,
                          fired: 1'b1, last: 1'b1};
        end
    end

    // The tick count only changes on an accepted request, which needs the
    // result register to be free, so the live count is the count after the
    // step of the result on show.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'd0, tick_reg, out_reg.fired, out_reg.owner, out_reg.id,
                       out_reg.status};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Full)
        else $error("active count exceeds table size");

    a_reports_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= lim_reg || state_reg == S_IDLE)
        else $error("check reported more timers than its limit");

    a_ring_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_SCAN |=> $stable(rec[0]) || $past(state_reg) == S_SCAN)
        else $error("slot ring moved outside a scan");
`endif

endmodule
`default_nettype wire
